>>> src/morse_character_keyer_core_defines.svh
// Assertion helpers shared by the keyer RTL.
`ifndef MORSE_CHARACTER_KEYER_CORE_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_CORE_DEFINES_SVH

// Check a property on every rising edge while reset is released.
`define MCK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define MCK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mck_pkg.sv
package mck_pkg;

    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [2:0] WORD_GAP_DITS = 3'd7;
    localparam logic [2:0] CHAR_GAP_DITS = 3'd2;
    localparam logic [2:0] DOT_DITS      = 3'd1;
    localparam logic [2:0] DASH_DITS     = 3'd3;
    localparam logic [2:0] OFF_DITS      = 3'd1;
    localparam logic [2:0] MAX_ELEMS     = 3'd6;
    localparam int unsigned LetterCount  = 26;

    // Packed codes: letters A..Z then digits 0..9
    localparam logic [7:0] ALNUM_CODES [0:35] = '{
        8'h42, 8'h81, 8'hA1, 8'h86, 8'h04, 8'h21, 8'hC6, 8'h01, 8'h02, 8'h79,
        8'hA6, 8'h41, 8'hC2, 8'h82, 8'hE6, 8'h61, 8'hD1, 8'h46, 8'h06, 8'h84,
        8'h26, 8'h11, 8'h66, 8'h91, 8'hB1, 8'hC1,
        8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_SPACE,
        ST_GAP
    } t_state;

    typedef struct packed {
        logic [7:0] code;
        logic [2:0] count;
        logic       is_space;
    } t_code;

    // Map an ASCII byte to its packed Morse code; zero when not in the table.
    function automatic logic [7:0] lookup_packed(input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] res;
        lo  = c | 8'h20;
        res = 8'h00;
        if (lo >= 8'h61 && lo <= 8'h7A) begin
            res = ALNUM_CODES[6'(lo - 8'h61)];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            res = ALNUM_CODES[6'(c - 8'h30) + 6'(LetterCount)];
        end else begin
            case (c)
                8'h2C:   res = 8'hCF;
                8'h2E:   res = 8'h57;
                8'h21:   res = 8'hAF;
                8'h3A:   res = 8'hE3;
                8'h3B:   res = 8'hAB;
                8'h28:   res = 8'hB5;
                8'h29:   res = 8'hB7;
                8'h22:   res = 8'h4B;
                8'h40:   res = 8'h6B;
                8'h26:   res = 8'h45;
                8'h3F:   res = 8'h33;
                8'h2D:   res = 8'h87;
                8'h2B:   res = 8'h55;
                8'h2F:   res = 8'h95;
                8'h3D:   res = 8'h8D;
                8'h2A:   res = 8'h91;
                8'h27:   res = 8'h7B;
                default: res = 8'h00;
            endcase
        end
        return res;
    endfunction

endpackage

>>> src/morse_character_keyer_core.sv
// Morse character keyer core.
// Input channel: i_valid / o_ready carry one ASCII byte (i_char_byte) per transfer.
// Output channel: o_valid / i_ready carry key segments: o_key_on, o_duration_dits
// (in dit units) and o_last_segment, which marks the closing gap of a character.
// A character of n elements (n up to 6) gives 2n+1 segments: mark, 1-dit space
// per element, then a 2-dit gap. A space gives one 7-dit gap; an unknown byte
// gives only the 2-dit gap.
// After a byte is accepted, the sequencer registers its code and state, then
// loads the first segment into the output register once that register is free.
// The sequencer steps one segment per cycle while the receiver does not stall;
// o_ready is high only while the sequencer is idle.
// The output register lets the next byte be accepted while the final segment
// of the previous character still waits to be taken.
// A stalled receiver freezes the sequencer; the waiting segment holds steady.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to idle.
`include "morse_character_keyer_core_defines.svh"

module morse_character_keyer_core import mck_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_key_on,
    output logic [2:0] o_duration_dits,
    output logic       o_last_segment
);

    t_state     r_state, n_state;
    logic [7:0] r_code, n_code;
    logic [2:0] r_left, n_left;
    logic       r_space, n_space;
    logic       r_out_valid, n_out_valid;
    logic       r_key_on, n_key_on;
    logic [2:0] r_dur, n_dur;
    logic       r_last, n_last;
    t_code      w_lut;
    logic       w_accept;
    logic       w_emit;
    logic       w_mark_ok;
    logic       w_gap_ok;
    logic       w_mark_taken;
    logic       w_space_out;

    mck_code_lut u_lut (
        .i_char_byte (i_char_byte),
        .o_code      (w_lut)
    );

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    // advance only when the output register is free or being drained
    assign w_emit   = (r_state != ST_IDLE) && (!r_out_valid || i_ready);

    // Next state and sequencer datapath
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_left  = r_left;
        n_space = r_space;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_code  = w_lut.code;
                    n_left  = w_lut.count;
                    n_space = w_lut.is_space;
                    if (w_lut.is_space || w_lut.count == 3'd0) begin
                        n_state = ST_GAP;
                    end else begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_MARK: begin
                if (w_emit) begin
                    n_state = ST_SPACE;
                end
            end
            ST_SPACE: begin
                if (w_emit) begin
                    n_code = {r_code[6:0], 1'b0};
                    n_left = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        n_state = ST_GAP;
                    end else begin
                        n_state = ST_MARK;
                    end
                end
            end
            ST_GAP: begin
                if (w_emit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output register load
    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_key_on    = r_key_on;
        n_dur       = r_dur;
        n_last      = r_last;
        if (w_emit) begin
            n_out_valid = 1'b1;
            case (r_state)
                ST_MARK: begin
                    n_key_on = 1'b1;
                    n_dur    = r_code[7] ? DASH_DITS : DOT_DITS;
                    n_last   = 1'b0;
                end
                ST_SPACE: begin
                    n_key_on = 1'b0;
                    n_dur    = OFF_DITS;
                    n_last   = 1'b0;
                end
                default: begin
                    n_key_on = 1'b0;
                    n_dur    = r_space ? WORD_GAP_DITS : CHAR_GAP_DITS;
                    n_last   = 1'b1;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code   <= n_code;
        r_left   <= n_left;
        r_space  <= n_space;
        r_key_on <= n_key_on;
        r_dur    <= n_dur;
        r_last   <= n_last;
    end

    assign o_valid         = r_out_valid;
    assign o_key_on        = r_key_on;
    assign o_duration_dits = r_dur;
    assign o_last_segment  = r_last;

    // Segment shape terms for the checks below
    assign w_mark_ok    = !o_last_segment &&
                          (o_duration_dits == DOT_DITS || o_duration_dits == DASH_DITS);
    assign w_gap_ok     = !o_key_on &&
                          (o_duration_dits == CHAR_GAP_DITS || o_duration_dits == WORD_GAP_DITS);
    assign w_mark_taken = o_valid && i_ready && o_key_on;
    assign w_space_out  = o_valid && !o_key_on && (o_duration_dits == OFF_DITS);

    `MCK_ASSERT(a_mark_shape, !(o_valid && o_key_on) || w_mark_ok, "mark segment malformed")
    `MCK_ASSERT_NEXT(a_space_after_mark, w_mark_taken, w_space_out, "mark not followed by space")
    `MCK_ASSERT_NEXT(a_busy_after_accept, w_accept, !o_ready, "sequencer idle after accept")
    `MCK_ASSERT(a_gap_is_last, !(o_valid && o_last_segment) || w_gap_ok, "closing segment malformed")

endmodule

>>> src/mck_code_lut.sv
module mck_code_lut import mck_pkg::*; (
    input  logic [7:0] i_char_byte,
    output t_code      o_code
);

    logic [7:0] w_packed;
    logic [2:0] w_count;

    // Look up the code, unscramble the bit-reversed element count and clamp it to MAX_ELEMS
    always_comb begin
        w_packed = lookup_packed(i_char_byte);
        w_count  = {w_packed[0], w_packed[1], w_packed[2]};
        if (w_count > MAX_ELEMS) begin
            w_count = MAX_ELEMS;
        end
        o_code.code     = w_packed;
        o_code.count    = w_count;
        o_code.is_space = (i_char_byte == CHAR_SPACE);
    end

endmodule
